// ===== rtl/ntts_pkg.sv =====
// Shared types and constants of the note table tone sequencer.
package ntts_pkg;

  // Field widths of the input and result words.
  localparam int unsigned IndexW    = 5;
  localparam int unsigned NoteW     = 8;
  localparam int unsigned DurationW = 16;

  // Default song table depth and the reset value of the gap length register.
  localparam int unsigned SongDepthDefault = 32;
  localparam logic [NoteW-1:0] GapLengthReset = 8'd200;

  // Operation carried by an input word.
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  // One song table entry: counter reload and length in half-periods.
  typedef struct packed {
    logic [NoteW-1:0]     note;
    logic [DurationW-1:0] len;
  } entry_t;

  // One result word.
  typedef struct packed {
    logic              sound;
    logic [IndexW-1:0] index;
    logic              gap;
  } result_t;

endpackage

// ===== rtl/note_table_tone_sequencer.sv =====
// Square-wave melody player built around a song table memory.
//
// Usage: input words arrive on in_valid_i/in_ready_o. A word with opcode_i
// set writes entry entry_index_i of the song table (note reload and length);
// indexes at or above SongDepth are dropped. A word with opcode_i clear is one
// prescaled tick; with sound_enable_i set it advances the 8-bit tick counter,
// and a counter wrap runs one sequencer step (toggle, count down, gap, next
// note, restart on a zero entry). Every input word yields exactly one result
// word (sound_out_o, playing_index_o, in_gap_o) on out_valid_o/out_ready_o.
// The result is registered into the output register, or into the skid stage
// while the output word is held. Throughput is one word per cycle, except that
// a step that moves on to the next table entry holds in_ready_o low while the
// entry after it is read from the registered song memory read port. A stalled
// receiver is absorbed by a one-word skid stage; when that fills, in_ready_o
// drops. The user must write gap_length through cfg_we_i/cfg_wdata_i only
// while the block is idle; the block does not enforce it. Reset clears all
// state, the table valid bits and output stages, and sets gap_length to 200.
module note_table_tone_sequencer
  import ntts_pkg::*;
#(
  parameter int unsigned SongDepth = SongDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [NoteW-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic                 sound_enable_i,
  input  logic [IndexW-1:0]    entry_index_i,
  input  logic [NoteW-1:0]     entry_note_i,
  input  logic [DurationW-1:0] entry_duration_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 sound_out_o,
  output logic [IndexW-1:0]    playing_index_o,
  output logic                 in_gap_o
);

  localparam int unsigned IdxW = $clog2(SongDepth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SongDepth - 1);

  // Position after p, wrapping at the end of the table.
  function automatic logic [IdxW-1:0] inc_pos(input logic [IdxW-1:0] p);
    if (p == LastIdx) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Song memory, its valid bits and its registered read port.
  entry_t                 mem_q [SongDepth];
  logic   [SongDepth-1:0] valid_q;
  entry_t                 rd_data_q;
  logic                   rd_valid_q;
  logic   [IdxW-1:0]      rd_addr;
  logic                   wr_en;
  logic   [IdxW-1:0]      wr_idx;
  entry_t                 wr_entry;

  // Sequencer state and cached table entries.
  logic [NoteW-1:0]     gap_len_q, gap_len_d;
  logic [NoteW-1:0]     tick_q, tick_d;
  logic [IdxW-1:0]      pos_q, pos_d;
  logic [DurationW-1:0] rc_q, rc_d;
  logic                 gap_q, gap_d;
  logic                 lvl_q, lvl_d;
  entry_t               cur_q, cur_d;   // entry at pos_q
  entry_t               nxt_q, nxt_d;   // entry after pos_q
  entry_t               e0_q, e0_d;     // entry 0
  entry_t               e1_q, e1_d;     // entry 1
  logic                 fetch_q, fetch_d;

  // Step intermediates.
  logic                 accept;
  logic                 in_range;
  logic                 restart;
  logic [IdxW-1:0]      p1, p2;
  logic [DurationW-1:0] rc1, rc2;
  entry_t               ent1, nxt1, ent2;
  logic                 gap2;
  logic                 moved;

  // Output register and skid stage.
  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    out_take;

  assign accept   = in_valid_i & in_ready_o;
  assign in_range = {4'b0, entry_index_i} < 9'(SongDepth);
  assign wr_idx   = IdxW'(entry_index_i);
  assign wr_entry = '{note: entry_note_i, len: entry_duration_i};

  // Next-state logic: table writes with cache forwarding, ticks and steps.
  always_comb begin
    tick_d  = tick_q;
    pos_d   = pos_q;
    rc_d    = rc_q;
    gap_d   = gap_q;
    lvl_d   = lvl_q;
    cur_d   = cur_q;
    nxt_d   = nxt_q;
    e0_d    = e0_q;
    e1_d    = e1_q;
    fetch_d = 1'b0;
    wr_en   = 1'b0;

    // First half of the step: a zero note restarts at entry 0.
    restart = (cur_q.note == '0);
    p1      = restart ? '0 : pos_q;
    rc1     = restart ? e0_q.len : rc_q;
    ent1    = restart ? e0_q : cur_q;
    nxt1    = restart ? e1_q : nxt_q;

    // Count expired: leave the gap for the next entry, or enter the gap.
    p2    = p1;
    rc2   = rc1;
    ent2  = ent1;
    gap2  = gap_q;
    moved = 1'b0;
    if (rc1 == '0) begin
      if (gap_q) begin
        gap2  = 1'b0;
        p2    = inc_pos(p1);
        ent2  = nxt1;
        rc2   = nxt1.len;
        moved = 1'b1;
      end else begin
        gap2 = 1'b1;
        rc2  = DurationW'(gap_len_q);
      end
    end
    rd_addr = inc_pos(p2);

    // The fetched entry lands in the next-entry cache.
    if (fetch_q) begin
      nxt_d = rd_valid_q ? rd_data_q : '0;
    end

    if (accept) begin
      if (opcode_i == OP_WRITE) begin
        if (in_range) begin
          wr_en = 1'b1;
          if (wr_idx == pos_q) begin
            cur_d = wr_entry;
          end
          if (wr_idx == inc_pos(pos_q)) begin
            nxt_d = wr_entry;
          end
          if (wr_idx == '0) begin
            e0_d = wr_entry;
          end
          if (wr_idx == IdxW'(1)) begin
            e1_d = wr_entry;
          end
        end
      end else if (sound_enable_i) begin
        tick_d = tick_q + 1'b1;
        if (tick_q == '1) begin
          lvl_d = lvl_q ^ (~gap_q & (ent1.note != '0));
          gap_d = gap2;
          if (ent2.len == '0) begin
            // End of song: back to entry 0, counter runs free.
            pos_d = '0;
            rc_d  = e0_q.len;
            cur_d = e0_q;
            nxt_d = e1_q;
          end else begin
            tick_d = gap2 ? gap_len_q : ent2.note;
            pos_d  = p2;
            rc_d   = rc2 - 1'b1;
            cur_d  = ent2;
            if (moved) begin
              fetch_d = 1'b1;
            end else begin
              nxt_d = nxt1;
            end
          end
        end
      end
    end
  end

  assign res = '{sound: lvl_d, index: IndexW'(pos_d), gap: gap_d};

  // Song memory write and read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_entry;
    end
    rd_data_q  <= mem_q[rd_addr];
    rd_valid_q <= valid_q[rd_addr];
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_len_q <= GapLengthReset;
      tick_q    <= '0;
      pos_q     <= '0;
      rc_q      <= '0;
      gap_q     <= 1'b0;
      lvl_q     <= 1'b0;
      cur_q     <= '0;
      nxt_q     <= '0;
      e0_q      <= '0;
      e1_q      <= '0;
      fetch_q   <= 1'b0;
    end else begin
      gap_len_q <= gap_len_d;
      tick_q    <= tick_d;
      pos_q     <= pos_d;
      rc_q      <= rc_d;
      gap_q     <= gap_d;
      lvl_q     <= lvl_d;
      cur_q     <= cur_d;
      nxt_q     <= nxt_d;
      e0_q      <= e0_d;
      e1_q      <= e1_d;
      fetch_q   <= fetch_d;
    end
  end

  assign gap_len_d = cfg_we_i ? cfg_wdata_i : gap_len_q;

  // Output register with a skid stage behind it.
  assign out_take   = out_valid_q & out_ready_i;
  assign in_ready_o = ~skid_valid_q & ~fetch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sound_out_o     = out_q.sound;
  assign playing_index_o = out_q.index;
  assign in_gap_o        = out_q.gap;

  // The skid stage only fills behind a held output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word present without an output word");

  // A memory fetch only follows an accepted tick word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_q |-> $past(accept) && ($past(opcode_i) == OP_TICK))
    else $error("entry fetch without a preceding tick");

  // The playing position stays inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastIdx)
    else $error("playing position beyond the table");

endmodule

// ===== tb/sv/ntts_tb_pkg.sv =====
// Scoreboard class that predicts and checks the tone sequencer result words.
`timescale 1ns / 100ps

package ntts_tb_pkg;
  import ntts_pkg::*;

  class tone_scoreboard;
    // Mirror of the player state.
    logic [7:0]           wrap_ctr;
    logic [NoteW-1:0]     notes[SongDepthDefault];
    logic [DurationW-1:0] lengths[SongDepthDefault];
    int unsigned          pos;
    logic [DurationW-1:0] half_periods_left;
    logic                 gap;
    logic                 level;
    logic [NoteW-1:0]     gap_len;

    // Player outputs predicted for accepted words, oldest first.
    result_t              player_outputs[$];
    int unsigned          errors;

    function new();
      wrap_ctr = '0;
      for (int i = 0; i < SongDepthDefault; i++) begin
        notes[i]   = '0;
        lengths[i] = '0;
      end
      pos               = 0;
      half_periods_left = '0;
      gap               = 1'b0;
      level             = 1'b0;
      gap_len           = GapLengthReset;
      errors            = 0;
    endfunction

    function void set_gap_len(logic [NoteW-1:0] value);
      gap_len = value;
    endfunction

    // One sequencer step, run when the tick counter wraps to zero.
    function void run_wrap_step();
      // A zero note entry sends the song back to its start.
      if (notes[pos] == '0) begin
        pos               = 0;
        half_periods_left = lengths[0];
      end
      if (!gap && notes[pos] != '0) begin
        level = ~level;
      end
      // Count exhausted: leave the gap for the next note, or enter the gap.
      if (half_periods_left == '0) begin
        if (gap) begin
          gap               = 1'b0;
          pos               = (pos + 1) % SongDepthDefault;
          half_periods_left = lengths[pos];
        end else begin
          gap               = 1'b1;
          half_periods_left = DurationW'(gap_len);
        end
      end
      half_periods_left = half_periods_left - 1'b1;
      // A zero length ends the song; the counter then runs free.
      if (lengths[pos] == '0) begin
        pos               = 0;
        half_periods_left = lengths[0];
      end else if (gap) begin
        wrap_ctr = gap_len;
      end else begin
        wrap_ctr = notes[pos];
      end
    endfunction

    // Apply an accepted input word and queue the result it yields.
    function void note_word(opcode_e op, logic en, logic [IndexW-1:0] idx,
                            logic [NoteW-1:0] note, logic [DurationW-1:0] dur);
      result_t r;
      if (op == OP_WRITE) begin
        if (idx < SongDepthDefault) begin
          notes[idx]   = note;
          lengths[idx] = dur;
        end
      end else if (en) begin
        wrap_ctr = wrap_ctr + 1'b1;
        if (wrap_ctr == '0) begin
          run_wrap_step();
        end
      end
      r.sound = level;
      r.index = pos[IndexW-1:0];
      r.gap   = gap;
      player_outputs.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest prediction.
    function void check_word(logic sound, logic [IndexW-1:0] idx, logic in_gap);
      result_t want;
      if (player_outputs.size() == 0) begin
        $display("%0t: unexpected result word sound=%0d index=%0d gap=%0d",
                 $time, sound, idx, in_gap);
        errors++;
        return;
      end
      want = player_outputs.pop_front();
      if (sound !== want.sound) begin
        $display("%0t: sound_out expected %0d, got %0d", $time, want.sound, sound);
        errors++;
      end
      if (idx !== want.index) begin
        $display("%0t: playing_index expected %0d, got %0d", $time, want.index, idx);
        errors++;
      end
      if (in_gap !== want.gap) begin
        $display("%0t: in_gap expected %0d, got %0d", $time, want.gap, in_gap);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return player_outputs.size();
    endfunction

    // Predictions still waiting at the end count as failures.
    function void close();
      if (player_outputs.size() != 0) begin
        $display("%0t: %0d result words expected, %0d got", $time,
                 player_outputs.size(), 0);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/note_table_tone_sequencer_tb.sv =====
// Testbench top of the note table tone sequencer.
`timescale 1ns / 100ps

module note_table_tone_sequencer_tb;
  import ntts_pkg::*;
  import ntts_tb_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [NoteW-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 opcode_i;
  logic                 sound_enable_i;
  logic [IndexW-1:0]    entry_index_i;
  logic [NoteW-1:0]     entry_note_i;
  logic [DurationW-1:0] entry_duration_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 sound_out_o;
  logic [IndexW-1:0]    playing_index_o;
  logic                 in_gap_o;

  tone_scoreboard sb;
  int unsigned    words_sent;
  int unsigned    words_taken;
  logic           no_idle;
  logic           held_off;

  note_table_tone_sequencer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .sound_enable_i  (sound_enable_i),
    .entry_index_i   (entry_index_i),
    .entry_note_i    (entry_note_i),
    .entry_duration_i(entry_duration_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sound_out_o     (sound_out_o),
    .playing_index_o (playing_index_o),
    .in_gap_o        (in_gap_o)
  );

  // Free-running clock with a 10 ns period.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Offer one input word after a random pause and hold it until accepted.
  task automatic send_word(opcode_e op, logic en, logic [IndexW-1:0] idx,
                           logic [NoteW-1:0] note, logic [DurationW-1:0] dur);
    int unsigned idle;
    // Every fourth stretch of 150 words runs with no idling on either side.
    no_idle = ((words_sent / 150) % 4) == 3;
    idle = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (idle != 0) begin
      in_valid_i = 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    opcode_i         = op;
    sound_enable_i   = en;
    entry_index_i    = idx;
    entry_note_i     = note;
    entry_duration_i = dur;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(op, en, idx, note, dur);
    words_sent++;
  endtask

  // Receiver: random stalls per word, with one long hold-off to fill the block.
  task automatic take_words();
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (words_taken == 400 && !held_off) begin
        held_off = 1'b1;
        stall    = 300;
      end
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_word(sound_out_o, playing_index_o, in_gap_o);
      words_taken++;
    end
  endtask

  // Stop offering words and wait until every result word has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the gap length register while the block is idle.
  task automatic write_gap(logic [NoteW-1:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sb.set_gap_len(value);
  endtask

  // Random songs followed by bursts of ticks, with some stray table writes.
  task automatic play_random(int unsigned count);
    int unsigned          target;
    int unsigned          pick;
    int unsigned          n;
    int unsigned          ticks;
    logic [NoteW-1:0]     note;
    logic [DurationW-1:0] dur;
    target = words_sent + count;
    while (words_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
        // Fresh song at the start of the table, now and then the whole table.
        n = ($urandom_range(0, 5) == 0) ? SongDepthDefault : $urandom_range(1, 8);
        for (int unsigned i = 0; i < n; i++) begin
          case ($urandom_range(0, 7))
            0:       note = '0;
            1:       note = NoteW'($urandom_range(0, 255));
            default: note = NoteW'($urandom_range(240, 255));
          endcase
          case ($urandom_range(0, 11))
            0:       dur = '0;
            1:       dur = DurationW'($urandom);
            default: dur = DurationW'($urandom_range(1, 3));
          endcase
          send_word(OP_WRITE, 1'($urandom_range(0, 1)), IndexW'(i), note, dur);
        end
        if (n < SongDepthDefault && $urandom_range(0, 1) == 1) begin
          send_word(OP_WRITE, 1'($urandom_range(0, 1)), IndexW'(n), '0, '0);
        end
      end else if (pick == 3) begin
        send_word(OP_WRITE, 1'($urandom_range(0, 1)), IndexW'($urandom_range(0, 31)),
                  NoteW'($urandom_range(0, 255)), DurationW'($urandom));
      end else begin
        // Tick burst; the fields a tick ignores carry random values.
        ticks = $urandom_range(20, 120);
        repeat (ticks) begin
          send_word(OP_TICK, $urandom_range(0, 9) != 0, IndexW'($urandom_range(0, 31)),
                    NoteW'($urandom_range(0, 255)), DurationW'($urandom));
        end
      end
    end
  endtask

  // Main sequence: reset, directed words, then random phases per gap length.
  initial begin
    logic [NoteW-1:0] gap_values[4];
    int unsigned      phase_words[4];
    sb               = new();
    words_sent       = 0;
    words_taken      = 0;
    no_idle          = 1'b0;
    held_off         = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    opcode_i         = OP_TICK;
    sound_enable_i   = 1'b0;
    entry_index_i    = '0;
    entry_note_i     = '0;
    entry_duration_i = '0;
    out_ready_i      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    fork
      take_words();
    join_none

    // Directed: disabled ticks, field extremes, rests and end markers.
    send_word(OP_TICK, 1'b0, '0, '0, '0);
    send_word(OP_TICK, 1'b1, '1, '1, '1);
    send_word(OP_WRITE, 1'b0, 5'd0, 8'hFF, 16'd1);
    send_word(OP_WRITE, 1'b1, 5'd31, 8'h00, 16'hFFFF);
    send_word(OP_WRITE, 1'b0, 5'd1, 8'h00, 16'd2);
    send_word(OP_WRITE, 1'b1, 5'd2, 8'h01, 16'd0);
    send_word(OP_WRITE, 1'b0, 5'd30, 8'hAA, 16'h5555);
    send_word(OP_WRITE, 1'b1, 5'd21, 8'h55, 16'hAAAA);
    send_word(OP_WRITE, 1'b1, 5'd3, 8'hFE, 16'h8000);
    send_word(OP_TICK, 1'b0, 5'd10, 8'h80, 16'h0001);
    repeat (8) send_word(OP_TICK, 1'b1, '0, '0, '0);
    send_word(OP_TICK, 1'b0, '1, '1, '1);
    send_word(OP_WRITE, 1'b1, 5'd2, 8'hF0, 16'd3);
    send_word(OP_WRITE, 1'b0, 5'd3, 8'h00, 16'd0);
    repeat (4) send_word(OP_TICK, 1'b1, '1, '1, '1);

    gap_values[0]  = 8'd255;
    gap_values[1]  = 8'd0;
    gap_values[2]  = NoteW'($urandom_range(1, 254));
    gap_values[3]  = 8'd250;
    phase_words[0] = 1100;
    phase_words[1] = 250;
    phase_words[2] = 300;
    phase_words[3] = 330;
    for (int p = 0; p < 4; p++) begin
      write_gap(gap_values[p]);
      play_random(phase_words[p]);
    end

    settle();
    repeat (10) @(posedge clk_i);
    sb.close();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
